// File: rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// Bridge converter serial reader package
// Shared constants and transfer types for the serial reader block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsr_pkg;

  // Number of data bits shifted out of the converter per reading.
  localparam int DATA_BITS = 24;
  localparam int BIT_W     = $clog2(DATA_BITS + 1);
  localparam int ACC_W     = 32;
  localparam int VALUE_W   = 24;
  localparam int COUNT_W   = 8;
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_EXTRA_PULSES  = 2'd0;
  localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;
  localparam logic [1:0] REG_POWER_DOWN    = 2'd3;

  // Status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef struct packed {
    logic start_req;
    logic dout;
  } item_t;

  typedef struct packed {
    logic                      sck;
    logic                      busy_res;
    logic                      done_res;
    logic                      status;
    logic signed [VALUE_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic [1:0]         extra_pulses;
    logic [COUNT_W-1:0] sample_count;
    logic [ACC_W-1:0]   timeout_limit;
    logic               power_down;
  } cfg_t;

endpackage

// File: rtl/bsr_div.sv
// ----------------------------------------------------------------------------
// Bridge converter serial reader divider
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsr_div import bsr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ACC_W-1:0]          dividend,
  input  logic [COUNT_W-1:0]        divisor,
  output logic                      done,
  output logic signed [VALUE_W-1:0] quotient
);

  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   dvs;
  logic [ACC_W-1:0]     quo;
  logic                 neg;
  logic [COUNT_W:0]     trial;
  logic                 fits;
  logic [ACC_W-1:0]     quo_signed;

  assign trial      = {rem, quo[ACC_W-1]};
  assign fits       = trial >= {1'b0, dvs};
  assign quo_signed = neg ? (~quo + ACC_W'(1)) : quo;
  assign quotient   = quo_signed[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(ACC_W);
      end else if (running) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Work on the magnitude and fix the sign at the end.
      neg <= dividend[ACC_W-1];
      quo <= dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      if (fits) begin
        rem <= COUNT_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[COUNT_W-1:0];
      end
      quo <= {quo[ACC_W-2:0], fits};
    end
  end

endmodule

// File: rtl/bsr_tick.sv
// ----------------------------------------------------------------------------
// Bridge converter serial reader tick sequencer
// Per-tick state machine: wait for data ready, clock bits, gain pulses, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsr_tick import bsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  item_t              item,
  input  cfg_t               cfg,
  output res_t               res,
  output logic               div_req,
  output logic [ACC_W-1:0]   acc_out,
  output logic [COUNT_W-1:0] count_out
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WAIT     = 3'd1;
  localparam logic [2:0] PH_BIT_HI   = 3'd2;
  localparam logic [2:0] PH_BIT_LO   = 3'd3;
  localparam logic [2:0] PH_PULSE_HI = 3'd4;
  localparam logic [2:0] PH_PULSE_LO = 3'd5;

  logic [2:0]           phase, phase_next;
  logic [BIT_W-1:0]     bit_index, bit_index_next;
  logic [DATA_BITS-1:0] shift_data, shift_data_next;
  logic [1:0]           pulse_index, pulse_index_next;
  logic [ACC_W-1:0]     wait_count, wait_count_next;
  logic [ACC_W-1:0]     accumulator, accumulator_next;
  logic [COUNT_W-1:0]   readings_taken, readings_taken_next;

  logic [2:0]           cur;
  logic [1:0]           npulses;
  logic [COUNT_W-1:0]   ncount;
  logic [ACC_W-1:0]     raw;

  assign npulses = (cfg.extra_pulses == 2'd0) ? 2'd1 : cfg.extra_pulses;
  assign ncount  = (cfg.sample_count == '0) ? COUNT_W'(1) : cfg.sample_count;
  assign raw     = ACC_W'($signed(shift_data));

  assign acc_out   = accumulator_next;
  assign count_out = readings_taken_next;

  always_comb begin
    phase_next          = phase;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    pulse_index_next    = pulse_index;
    wait_count_next     = wait_count;
    accumulator_next    = accumulator;
    readings_taken_next = readings_taken;
    res                 = '0;
    div_req             = 1'b0;
    cur                 = phase;

    if (cfg.power_down) begin
      phase_next = PH_IDLE;
      res.sck    = 1'b1;
    end else begin
      // A start on an idle tick already counts as the first wait tick.
      if (phase == PH_IDLE && item.start_req) begin
        cur                 = PH_WAIT;
        phase_next          = PH_WAIT;
        wait_count_next     = '0;
        accumulator_next    = '0;
        readings_taken_next = '0;
      end
      unique case (cur)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_WAIT: begin
          res.busy_res = 1'b1;
          if (!item.dout) begin
            phase_next      = PH_BIT_HI;
            bit_index_next  = '0;
            shift_data_next = '0;
          end else begin
            if (wait_count_next != '1) begin
              wait_count_next = wait_count_next + ACC_W'(1);
            end
            if (cfg.timeout_limit != '0 && wait_count_next > cfg.timeout_limit) begin
              phase_next   = PH_IDLE;
              res.busy_res = 1'b0;
              res.done_res = 1'b1;
              res.status   = STATUS_TIMEOUT;
            end
          end
        end
        PH_BIT_HI: begin
          res.busy_res = 1'b1;
          res.sck      = 1'b1;
          phase_next   = PH_BIT_LO;
        end
        PH_BIT_LO: begin
          res.busy_res    = 1'b1;
          shift_data_next = {shift_data[DATA_BITS-2:0], item.dout};
          bit_index_next  = bit_index + BIT_W'(1);
          if (bit_index_next >= BIT_W'(DATA_BITS)) begin
            phase_next       = PH_PULSE_HI;
            pulse_index_next = '0;
          end else begin
            phase_next = PH_BIT_HI;
          end
        end
        PH_PULSE_HI: begin
          res.busy_res = 1'b1;
          res.sck      = 1'b1;
          phase_next   = PH_PULSE_LO;
        end
        PH_PULSE_LO: begin
          res.busy_res     = 1'b1;
          pulse_index_next = pulse_index + 2'd1;
          if (pulse_index_next < npulses) begin
            phase_next = PH_PULSE_HI;
          end else begin
            accumulator_next = accumulator + raw;
            if (readings_taken != '1) begin
              readings_taken_next = readings_taken + COUNT_W'(1);
            end
            if (readings_taken_next >= ncount) begin
              // The averaged value comes from the divider afterwards.
              phase_next   = PH_IDLE;
              res.busy_res = 1'b0;
              res.done_res = 1'b1;
              res.status   = STATUS_OK;
              div_req      = 1'b1;
            end else begin
              phase_next      = PH_WAIT;
              wait_count_next = '0;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_index      <= '0;
      shift_data     <= '0;
      pulse_index    <= '0;
      wait_count     <= '0;
      accumulator    <= '0;
      readings_taken <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      pulse_index    <= pulse_index_next;
      wait_count     <= wait_count_next;
      accumulator    <= accumulator_next;
      readings_taken <= readings_taken_next;
    end
  end

endmodule

// File: rtl/bridge_adc_serial_reader.sv
// ----------------------------------------------------------------------------
// Bridge converter serial reader
// Tick-level readout of a 24-bit bridge converter with averaging.
// ----------------------------------------------------------------------------
// Usage: every transfer on the item channel is one half period of the serial
// clock and carries start_req and the sampled data pin. Every item gives
// exactly one transfer on the result channel with the clock level to drive,
// busy and done flags, status and the averaged value.
// An ordinary tick's result is registered and valid in the cycle after its input
// transfer. The tick that completes a measurement starts the one-bit-per-cycle
// divider (32 iterations); that item's result is valid once the divider is done
// and the output is free; no item is taken while the divider runs or waits.
// An item is taken only when the result register is empty or being emptied
// in the same cycle, so a stalled result simply holds off the item channel.
// The configuration channel is always ready and must be written only while
// the block is idle. Reset returns the sequencer to idle, clears the
// accumulator and restores the register defaults (one extra pulse, one
// sample, no timeout, powered up); the result register is emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bridge_adc_serial_reader import bsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                state;
  cfg_t                      cfg;
  logic                      take;
  logic                      out_free;
  logic                      accept;
  res_t                      tick_res;
  logic                      div_req;
  logic [ACC_W-1:0]          acc;
  logic [COUNT_W-1:0]        count;
  logic                      div_done;
  logic signed [VALUE_W-1:0] quotient;
  res_t                      avg_res;

  assign cfg_ready  = 1'b1;
  assign take       = res_valid && !res_stall;
  assign out_free   = !res_valid || take;
  assign item_stall = !(state == ST_RUN && out_free);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    avg_res          = '0;
    avg_res.done_res = 1'b1;
    avg_res.status   = STATUS_OK;
    avg_res.value    = quotient;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extra_pulses  <= 2'd1;
      cfg.sample_count  <= COUNT_W'(1);
      cfg.timeout_limit <= '0;
      cfg.power_down    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXTRA_PULSES:  cfg.extra_pulses  <= cfg_data[1:0];
        REG_SAMPLE_COUNT:  cfg.sample_count  <= cfg_data[COUNT_W-1:0];
        REG_TIMEOUT_LIMIT: cfg.timeout_limit <= cfg_data[ACC_W-1:0];
        REG_POWER_DOWN:    cfg.power_down    <= cfg_data[0];
      endcase
    end
  end

  bsr_tick u_tick (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .item      (item),
    .cfg       (cfg),
    .res       (tick_res),
    .div_req   (div_req),
    .acc_out   (acc),
    .count_out (count)
  );

  bsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && div_req),
    .dividend (acc),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (accept) begin
            if (div_req) begin
              state <= ST_DIV;
            end else begin
              res_valid <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // The quotient stays put until the result register frees up.
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN && accept && !div_req) begin
      res <= tick_res;
    end else if (state == ST_HOLD && out_free) begin
      res <= avg_res;
    end
  end

endmodule
